/* hw/rtl/bfa_pkg.sv */
// Shared definitions for the bidirectional-fit block allocator.
// Holds default sizing, the fixed field widths and the result status codes.
// No dependencies.
package bfa_pkg;

	localparam int MAX_BLOCKS_DEF = 16;
	localparam int SIZE_WIDTH_DEF = 24;

	localparam int AMOUNT_W    = 16;
	localparam int REMAINING_W = 24;
	localparam int STATUS_W    = 2;

	typedef enum logic [STATUS_W-1:0] {
		STAT_ALLOC   = 2'd0,
		STAT_MEM_OUT = 2'd1,
		STAT_LOADED  = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

endpackage

/* hw/rtl/bfa_mem.sv */
// Block size store: one write port, one read port, registered read data.
// Generic simple dual-port memory used by the allocator controller.
// No package dependencies.
module bfa_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/bfa_ctrl.sv */
// Allocator sequencer: ring bookkeeping, scan, shift, merge and clear passes.
// Drives the block size store (bfa_mem) and holds the output register.
// Depends on bfa_pkg.
module bfa_ctrl #(
	parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_WIDTH = bfa_pkg::SIZE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [bfa_pkg::AMOUNT_W-1:0]      amount,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bfa_pkg::STATUS_W-1:0]      status,
	output logic [bfa_pkg::REMAINING_W-1:0]   remaining,
	output logic                              mem_we,
	output logic [$clog2(MAX_BLOCKS)-1:0]     mem_waddr,
	output logic [SIZE_WIDTH-1:0]             mem_wdata,
	output logic [$clog2(MAX_BLOCKS)-1:0]     mem_raddr,
	input  logic [SIZE_WIDTH-1:0]             mem_rdata
);

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int TW = SIZE_WIDTH + CW;
	localparam int XW = (SIZE_WIDTH > bfa_pkg::AMOUNT_W) ? SIZE_WIDTH : bfa_pkg::AMOUNT_W;
	localparam int MW = (TW > bfa_pkg::AMOUNT_W) ? TW : bfa_pkg::AMOUNT_W;
	localparam int XR = (SIZE_WIDTH > bfa_pkg::REMAINING_W) ? SIZE_WIDTH : bfa_pkg::REMAINING_W;
	localparam logic [SIZE_WIDTH-1:0] SIZE_TOP = '1;
	localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_BLOCKS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_MERGE,
		S_ZERO,
		S_RESP
	} state_t;

	state_t                          state_q;
	logic [CW-1:0]                   count_q;
	logic [AW-1:0]                   head_q;
	logic [CW-1:0]                   k_q;
	logic                            rv_s1;
	logic                            last_s1;
	logic [CW-1:0]                   pos_s1;
	logic [TW-1:0]                   total_q;
	logic [bfa_pkg::AMOUNT_W-1:0]    amount_q;
	bfa_pkg::status_t                res_status_q;
	logic [bfa_pkg::REMAINING_W-1:0] res_rem_q;
	logic                            out_valid_q;
	bfa_pkg::status_t                status_q;
	logic [bfa_pkg::REMAINING_W-1:0] remaining_q;

	logic                            in_fire;
	logic                            fit;
	logic [SIZE_WIDTH-1:0]           fit_left;
	logic [SIZE_WIDTH-1:0]           load_val;
	logic                            merge_ok;
	logic [MW-1:0]                   merge_diff;
	logic [SIZE_WIDTH-1:0]           merge_val;
	logic [CW-1:0]                   scan_pos;

	// Physical slot of a ring position: head plus offset, wrapped once.
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
			input logic [CW-1:0] pos);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(pos);
		if (sum >= (CW+1)'(MAX_BLOCKS)) begin
			sum = sum - (CW+1)'(MAX_BLOCKS);
		end
		return AW'(sum);
	endfunction

	// Scan order: head, then alternately tail side and the entry after head.
	function automatic logic [CW-1:0] order_pos(input logic [CW-1:0] k,
			input logic [CW-1:0] cnt);
		logic [CW-1:0] half;
		half = (k + CW'(1)) >> 1;
		if (k == '0) begin
			return '0;
		end else if (k[0]) begin
			return cnt - half;
		end else begin
			return k >> 1;
		end
	endfunction

	function automatic logic [bfa_pkg::REMAINING_W-1:0] rem_of(
			input logic [SIZE_WIDTH-1:0] v);
		return bfa_pkg::REMAINING_W'(XR'(v));
	endfunction

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign remaining = remaining_q;

	assign scan_pos = order_pos(k_q, count_q);
	assign fit      = (XW'(mem_rdata) >= XW'(amount_q));
	assign fit_left = SIZE_WIDTH'(XW'(mem_rdata) - XW'(amount_q));
	assign load_val = (XW'(amount) > XW'(SIZE_TOP)) ? SIZE_TOP : SIZE_WIDTH'(XW'(amount));

	assign merge_ok   = (MW'(total_q) >= MW'(amount_q));
	assign merge_diff = MW'(total_q) - MW'(amount_q);
	assign merge_val  = (merge_diff > MW'(SIZE_TOP)) ? SIZE_TOP : SIZE_WIDTH'(merge_diff);

	// Store accesses; every write lands before a read of the same slot is issued,
	// so no forwarding path is needed.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_of(head_q, pos_s1);
		mem_wdata = '0;
		mem_raddr = slot_of(head_q, scan_pos);
		case (state_q)
			S_IDLE: begin
				if (in_fire && !kind && count_q != COUNT_FULL) begin
					mem_we    = 1'b1;
					mem_waddr = slot_of(head_q, count_q);
					mem_wdata = load_val;
				end
			end
			S_SCAN: begin
				if (rv_s1 && fit) begin
					mem_we    = 1'b1;
					mem_wdata = fit_left;
				end
			end
			S_SHIFT: begin
				mem_raddr = slot_of(head_q, k_q);
				if (rv_s1) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata;
				end
			end
			S_MERGE: begin
				if (merge_ok) begin
					mem_we    = 1'b1;
					mem_waddr = head_q;
					mem_wdata = merge_val;
				end
			end
			S_ZERO: begin
				if (k_q < count_q) begin
					mem_we    = 1'b1;
					mem_waddr = slot_of(head_q, k_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			head_q       <= '0;
			k_q          <= '0;
			rv_s1        <= 1'b0;
			last_s1      <= 1'b0;
			pos_s1       <= '0;
			total_q      <= '0;
			amount_q     <= '0;
			res_status_q <= bfa_pkg::STAT_ALLOC;
			res_rem_q    <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= bfa_pkg::STAT_ALLOC;
			remaining_q  <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						amount_q  <= amount;
						res_rem_q <= '0;
						k_q       <= '0;
						rv_s1     <= 1'b0;
						total_q   <= '0;
						if (!kind) begin
							if (count_q == COUNT_FULL) begin
								res_status_q <= bfa_pkg::STAT_FULL;
							end else begin
								count_q      <= count_q + CW'(1);
								res_status_q <= bfa_pkg::STAT_LOADED;
							end
							state_q <= S_RESP;
						end else if (count_q == '0) begin
							res_status_q <= bfa_pkg::STAT_MEM_OUT;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rv_s1 && fit) begin
						rv_s1        <= 1'b0;
						res_status_q <= bfa_pkg::STAT_ALLOC;
						res_rem_q    <= rem_of(fit_left);
						if (fit_left != '0) begin
							state_q <= S_RESP;
						end else if (pos_s1 == '0) begin
							// drop the emptied head
							head_q  <= slot_of(head_q, CW'(1));
							count_q <= count_q - CW'(1);
							state_q <= S_RESP;
						end else begin
							k_q     <= pos_s1 + CW'(1);
							state_q <= S_SHIFT;
						end
					end else if (rv_s1 && last_s1) begin
						rv_s1   <= 1'b0;
						total_q <= total_q + TW'(mem_rdata);
						state_q <= S_MERGE;
					end else begin
						if (rv_s1) begin
							total_q <= total_q + TW'(mem_rdata);
						end
						if (k_q < count_q) begin
							rv_s1   <= 1'b1;
							pos_s1  <= scan_pos;
							last_s1 <= (k_q == count_q - CW'(1));
							k_q     <= k_q + CW'(1);
						end else begin
							rv_s1 <= 1'b0;
						end
					end
				end
				S_SHIFT: begin
					// close up: read position k, write it one place toward the head
					if (k_q < count_q) begin
						rv_s1  <= 1'b1;
						pos_s1 <= k_q - CW'(1);
						k_q    <= k_q + CW'(1);
					end else begin
						rv_s1 <= 1'b0;
						if (!rv_s1) begin
							count_q <= count_q - CW'(1);
							state_q <= S_RESP;
						end
					end
				end
				S_MERGE: begin
					if (merge_ok) begin
						res_status_q <= bfa_pkg::STAT_ALLOC;
						res_rem_q    <= rem_of(merge_val);
						k_q          <= CW'(1);
						state_q      <= S_ZERO;
					end else begin
						res_status_q <= bfa_pkg::STAT_MEM_OUT;
						res_rem_q    <= '0;
						state_q      <= S_RESP;
					end
				end
				S_ZERO: begin
					if (k_q < count_q) begin
						k_q <= k_q + CW'(1);
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						remaining_q <= res_rem_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/bidirectional_fit_block_allocator_top.sv */
// Top level of the bidirectional-fit block allocator.
// Instantiates the sequencer (bfa_ctrl) and the block size store (bfa_mem).
// Depends on bfa_pkg.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_ready, kind, amount | into block
//  out     | out_valid, out_ready, status,    | out of block
//          | remaining                        |
//
// One transaction at a time. A load passes through the response state into the output register.
// An allocation scans the ring with one store read per cycle, then, where needed, makes a
// shift or clear pass with one store write per cycle; the single read and single write
// port set these rates.
// arst_n clears the ring to empty; the store itself is not cleared.
// A stalled result sits in the output register while the next transaction is taken.
module bidirectional_fit_block_allocator_top #(
	parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_WIDTH = bfa_pkg::SIZE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic [bfa_pkg::AMOUNT_W-1:0]    amount,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bfa_pkg::STATUS_W-1:0]    status,
	output logic [bfa_pkg::REMAINING_W-1:0] remaining
);

	localparam int AW = $clog2(MAX_BLOCKS);

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [SIZE_WIDTH-1:0] mem_wdata;
	logic [AW-1:0]         mem_raddr;
	logic [SIZE_WIDTH-1:0] mem_rdata;

	bfa_ctrl #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SIZE_WIDTH (SIZE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.amount    (amount),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.remaining (remaining),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bfa_mem #(
		.DEPTH (MAX_BLOCKS),
		.WIDTH (SIZE_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

/* bench/bfa_allocation_checker.sv */
// Result checker for the bidirectional-fit block allocator bench.
// Watches both channels, keeps its own copy of the free ring, predicts each result and compares.
// Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_allocation_checker #(
	parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_WIDTH = bfa_pkg::SIZE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            kind,
	input  logic [bfa_pkg::AMOUNT_W-1:0]    amount,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [bfa_pkg::STATUS_W-1:0]    status,
	input  logic [bfa_pkg::REMAINING_W-1:0] remaining,
	output int                              fail_count,
	output int                              awaiting_count
);

	typedef struct packed {
		bfa_pkg::status_t                status;
		logic [bfa_pkg::REMAINING_W-1:0] remaining;
	} alloc_result_t;

	localparam logic [63:0] SIZE_TOP = (64'd1 << SIZE_WIDTH) - 64'd1;

	logic [SIZE_WIDTH-1:0] free_size [MAX_BLOCKS];
	int                    free_count;
	int                    free_head;
	logic [63:0]           served_left;
	alloc_result_t         awaited_results [$];
	alloc_result_t         want;
	int                    errors;

	function automatic int ring_slot(int pos);
		return (free_head + pos) % MAX_BLOCKS;
	endfunction

	// Drop one entry; later entries close up toward the head.
	function automatic void close_gap(int pos);
		int j;
		if (free_count == 0)
			return;
		if (pos == 0) begin
			free_head = (free_head + 1) % MAX_BLOCKS;
		end else begin
			for (j = pos; j + 1 < free_count; j++)
				free_size[ring_slot(j)] = free_size[ring_slot(j + 1)];
		end
		free_count--;
	endfunction

	function automatic bit serve_from(int pos, logic [63:0] req);
		int          s;
		logic [63:0] v;
		s = ring_slot(pos);
		v = 64'(free_size[s]);
		if (v < req)
			return 1'b0;
		v = v - req;
		free_size[s] = SIZE_WIDTH'(v);
		served_left = v;
		if (v == 64'd0)
			close_gap(pos);
		return 1'b1;
	endfunction

	function automatic alloc_result_t predict_result(logic k,
			logic [bfa_pkg::AMOUNT_W-1:0] a);
		alloc_result_t r;
		logic [63:0]   req;
		logic [63:0]   total;
		int            lo;
		int            hi;
		int            i;
		req = 64'(a);
		r.remaining = '0;
		r.status = bfa_pkg::STAT_MEM_OUT;
		if (k == 1'b0) begin
			if (free_count >= MAX_BLOCKS) begin
				r.status = bfa_pkg::STAT_FULL;
			end else begin
				free_size[ring_slot(free_count)] = SIZE_WIDTH'((req > SIZE_TOP) ? SIZE_TOP : req);
				free_count++;
				r.status = bfa_pkg::STAT_LOADED;
			end
			return r;
		end
		if (free_count == 0)
			return r;
		if (serve_from(0, req)) begin
			r.status = bfa_pkg::STAT_ALLOC;
			r.remaining = bfa_pkg::REMAINING_W'(served_left);
			return r;
		end
		// Scan inward, tail side first, then the side after the head.
		lo = 1;
		hi = free_count - 1;
		while (lo <= hi) begin
			if (serve_from(hi, req) || (lo != hi && serve_from(lo, req))) begin
				r.status = bfa_pkg::STAT_ALLOC;
				r.remaining = bfa_pkg::REMAINING_W'(served_left);
				return r;
			end
			lo++;
			hi--;
		end
		total = 64'd0;
		for (i = 0; i < free_count; i++)
			total = total + 64'(free_size[ring_slot(i)]);
		if (total >= req) begin
			// Merge into the head; zeroed entries stay in the ring.
			total = total - req;
			if (total > SIZE_TOP)
				total = SIZE_TOP;
			for (i = 1; i < free_count; i++)
				free_size[ring_slot(i)] = '0;
			free_size[ring_slot(0)] = SIZE_WIDTH'(total);
			r.status = bfa_pkg::STAT_ALLOC;
			r.remaining = bfa_pkg::REMAINING_W'(total);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_count = 0;
			free_head = 0;
			errors = 0;
			awaited_results.delete();
			fail_count <= 0;
			awaiting_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result transaction with nothing expected: status %0d remaining %0d",
						$time, status, remaining);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time, want.status, status);
						errors++;
					end
					if (remaining !== want.remaining) begin
						$display("%0t: remaining expected %0d actual %0d",
							$time, want.remaining, remaining);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				awaited_results.push_back(predict_result(kind, amount));
			fail_count <= errors;
			awaiting_count <= awaited_results.size();
		end
	end

endmodule

/* bench/bidirectional_fit_block_allocator_top_tb.sv */
// Top of the bidirectional-fit block allocator bench: clock, reset, stimulus and verdict.
// Depends on bfa_pkg, bidirectional_fit_block_allocator_top and bfa_allocation_checker.
`timescale 1ns / 1ps

module bidirectional_fit_block_allocator_top_tb;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_ALLOC = 1'b1;
	localparam int   RANDOM_ITEMS = 1200;
	localparam int   STALL_LIMIT  = 3000;
	localparam int   HOLD_AT      = 300;
	localparam int   HOLD_CYCLES  = 400;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic                            kind = 1'b0;
	logic [bfa_pkg::AMOUNT_W-1:0]    amount = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [bfa_pkg::STATUS_W-1:0]    status;
	logic [bfa_pkg::REMAINING_W-1:0] remaining;

	int fail_count;
	int awaiting_count;
	int stall_cycles = 0;
	bit send_burst = 1'b0;

	always #2 clk = ~clk;

	bidirectional_fit_block_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.amount    (amount),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.remaining (remaining)
	);

	bfa_allocation_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.amount         (amount),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.remaining      (remaining),
		.fail_count     (fail_count),
		.awaiting_count (awaiting_count)
	);

	// Offer one transaction; valid is only lowered when a gap is drawn.
	task automatic send_item(logic k, logic [bfa_pkg::AMOUNT_W-1:0] a);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		amount <= a;
		do @(posedge clk); while (!in_ready);
	endtask

	initial begin
		int                           i;
		int                           phase_left;
		int                           load_pct;
		int                           pick;
		logic                         k;
		logic [bfa_pkg::AMOUNT_W-1:0] a;
		phase_left = 0;
		load_pct = 50;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(KIND_ALLOC, 16'd0);      // empty ring
		send_item(KIND_LOAD, 16'd0);
		send_item(KIND_ALLOC, 16'd0);      // zero head served, ring empties
		send_item(KIND_ALLOC, 16'hFFFF);
		send_item(KIND_LOAD, 16'd100);
		send_item(KIND_LOAD, 16'd200);
		send_item(KIND_LOAD, 16'd300);
		send_item(KIND_LOAD, 16'd400);
		send_item(KIND_ALLOC, 16'd350);    // tail fits
		send_item(KIND_ALLOC, 16'd250);    // scans meet in the middle
		send_item(KIND_ALLOC, 16'd200);    // non-head entry removed
		send_item(KIND_ALLOC, 16'd150);    // merge into head
		send_item(KIND_ALLOC, 16'd60);     // total too small
		send_item(KIND_ALLOC, 16'd50);     // head reaches zero
		send_item(KIND_LOAD, 16'd20);
		send_item(KIND_ALLOC, 16'd20);
		send_item(KIND_ALLOC, 16'd0);
		send_item(KIND_LOAD, 16'd10);
		send_item(KIND_LOAD, 16'd20);
		send_item(KIND_ALLOC, 16'd30);     // merge leaves zero in the head
		for (i = 0; i < 14; i++)
			send_item(KIND_LOAD, 16'hFFFF); // last one finds the ring full
		send_item(KIND_ALLOC, 16'hFFFF);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(30, 60);
				load_pct = $urandom_range(15, 85);
				send_burst = ($urandom_range(0, 3) == 0);
			end
			phase_left--;
			k = ($urandom_range(0, 99) >= load_pct) ? KIND_ALLOC : KIND_LOAD;
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				case ($urandom_range(0, 3))
					0: a = 16'h0000;
					1: a = 16'h0001;
					2: a = 16'hFFFE;
					default: a = 16'hFFFF;
				endcase
			end else if (pick < 40) begin
				a = 16'($urandom_range(0, 15));
			end else if (pick < 70) begin
				a = 16'($urandom_range(0, 1023));
			end else begin
				a = 16'($urandom);
			end
			send_item(k, a);
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (awaiting_count != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Result side: random stalls, calm stretches, and one long hold-off.
	initial begin
		int gap;
		int left_in_mode;
		int got;
		bit calm;
		left_in_mode = 0;
		got = 0;
		calm = 1'b0;
		wait (arst_n);
		forever begin
			if (left_in_mode == 0) begin
				left_in_mode = $urandom_range(20, 80);
				calm = ($urandom_range(0, 3) == 0);
			end
			left_in_mode--;
			if (got == HOLD_AT)
				gap = HOLD_CYCLES;
			else
				gap = calm ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

endmodule
